// ===== hw/rtl/pcics_pkg.sv =====
// ----------------------------------------------------------------------------
// pcics_pkg
// Shared types, codes and helper functions of the configuration port unit:
// port and size codes, lane merge and extract, preset table, narrow modulo.
// ----------------------------------------------------------------------------
package pcics_pkg;

   // stream payload widths
   localparam int REQ_DATA_W = 40;
   localparam int REQ_USER_W = 3;
   localparam int RSP_DATA_W = 32;
   localparam int RSP_USER_W = 1;

   // port codes
   localparam logic [1:0] KIND_ADDR = 2'd0;
   localparam logic [1:0] KIND_DATA = 2'd1;

   // access size codes
   localparam logic [1:0] SIZE_BYTE  = 2'd0;
   localparam logic [1:0] SIZE_WORD  = 2'd1;
   localparam logic [1:0] SIZE_DWORD = 2'd2;

   // command from the control path to the store
   typedef struct packed {
      logic rd;
      logic wr;
   } store_cmd_type;

   // status from the store to the control path
   typedef struct packed {
      logic busy;
   } store_stat_type;

   // reset contents of one store entry, by function slot and dword
   function automatic logic [31:0] preset_value(input logic [7:0] slot, input logic [5:0] dw);
      logic [31:0] value;
      value = 32'h0;
      case ({slot, dw})
         {8'd0, 6'd0}:   value = 32'h12378086;
         {8'd0, 6'd1}:   value = 32'h02800006;
         {8'd0, 6'd2}:   value = 32'h06000002;
         {8'd0, 6'd11}:  value = 32'h11001af4;
         {8'd0, 6'd24}:  value = 32'h00000001;
         {8'd16, 6'd0}:  value = 32'h01668086;
         {8'd16, 6'd2}:  value = 32'h03000000;
         default:        value = 32'h0;
      endcase
      return value;
   endfunction

   // remainder of a narrow value by a constant, restoring steps
   function automatic logic [7:0] mod_narrow(input logic [7:0] value, input int unsigned divisor);
      logic [31:0] rem;
      logic [31:0] step;
      rem = {24'h0, value};
      for (int k = 7; k >= 0; k--) begin
         step = divisor << k;
         if (rem >= step) begin
            rem = rem - step;
         end
      end
      return rem[7:0];
   endfunction

   // new dword after a write of the given size at the given lane
   function automatic logic [31:0] lane_merge(input logic [31:0] word, input logic [31:0] data,
                                              input logic [1:0] lane, input logic [1:0] size);
      logic [4:0]  sh;
      logic [31:0] mask;
      logic [31:0] result;
      sh = {lane, 3'b000};
      result = word;
      case (size)
         SIZE_BYTE: begin
            mask = 32'h0000_00ff << sh;
            result = (word & ~mask) | ((data & 32'h0000_00ff) << sh);
         end
         SIZE_WORD: begin
            mask = 32'h0000_ffff << sh;
            result = (word & ~mask) | ((data & 32'h0000_ffff) << sh);
         end
         SIZE_DWORD: result = data;
         default:    result = word;
      endcase
      return result;
   endfunction

   // read value of the given size at the given lane, zero-extended
   function automatic logic [31:0] lane_extract(input logic [31:0] word, input logic [1:0] lane,
                                                input logic [1:0] size);
      logic [4:0]  sh;
      logic [31:0] result;
      sh = {lane, 3'b000};
      case (size)
         SIZE_BYTE:  result = (word >> sh) & 32'h0000_00ff;
         SIZE_WORD:  result = (word >> sh) & 32'h0000_ffff;
         SIZE_DWORD: result = word;
         default:    result = 32'h0;
      endcase
      return result;
   endfunction

endpackage

// ===== hw/rtl/pcics_store.sv =====
// ----------------------------------------------------------------------------
// pcics_store
// Configuration space store: single-port synchronous memory with a registered
// read and a sweep after reset that loads zeros and the presets.
// ----------------------------------------------------------------------------
module pcics_store #(
   parameter int NUM_FUNCTION_SLOTS = 256,
   parameter int DWORDS_PER_SPACE   = 64
) (
   input  logic                            clock,
   input  logic                            reset,
   input  pcics_pkg::store_cmd_type        cmd,
   input  logic [$clog2(NUM_FUNCTION_SLOTS*DWORDS_PER_SPACE)-1:0] addr,
   input  logic [31:0]                     wr_data,
   output logic [31:0]                     rd_data,
   output pcics_pkg::store_stat_type       stat
);
   import pcics_pkg::*;

   localparam int DEPTH  = NUM_FUNCTION_SLOTS * DWORDS_PER_SPACE;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int SLOT_W = $clog2(NUM_FUNCTION_SLOTS);
   localparam int DW_W   = $clog2(DWORDS_PER_SPACE);

   logic [31:0]       mem [DEPTH];
   logic [31:0]       rd_data_ff;
   logic              busy_ff;
   logic [ADDR_W-1:0] cnt_ff;
   logic [SLOT_W-1:0] slot_cnt_ff;
   logic [DW_W-1:0]   dw_cnt_ff;
   logic              cnt_last;
   logic              dw_last;

   assign cnt_last = (cnt_ff == ADDR_W'(DEPTH - 1));
   assign dw_last  = (dw_cnt_ff == DW_W'(DWORDS_PER_SPACE - 1));

   // clearing sweep counters
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff     <= 1'b1;
         cnt_ff      <= '0;
         slot_cnt_ff <= '0;
         dw_cnt_ff   <= '0;
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff + 1'b1;
         if (dw_last) begin
            dw_cnt_ff   <= '0;
            slot_cnt_ff <= slot_cnt_ff + 1'b1;
         end else begin
            dw_cnt_ff <= dw_cnt_ff + 1'b1;
         end
         if (cnt_last) begin
            busy_ff <= 1'b0;
         end
      end
   end

   // memory array, sweep or item write, registered read
   always_ff @(posedge clock) begin
      if (busy_ff) begin
         mem[cnt_ff] <= preset_value(8'(slot_cnt_ff), 6'(dw_cnt_ff));
      end else if (cmd.wr) begin
         mem[addr] <= wr_data;
      end
      if (cmd.rd) begin
         rd_data_ff <= mem[addr];
      end
   end

   assign rd_data   = rd_data_ff;
   assign stat.busy = busy_ff;

endmodule

// ===== hw/rtl/pci_config_space_port_unit.sv =====
// ----------------------------------------------------------------------------
// pci_config_space_port_unit
// Configuration mechanism with an address port and a data port in front of a
// per-function dword store.
// ----------------------------------------------------------------------------
// After reset the unit sweeps all NUM_FUNCTION_SLOTS*DWORDS_PER_SPACE store
// entries (16384 with the defaults), loading zeros and the host bridge and
// display device presets; no item is taken during the sweep. After that the
// store is read in the cycle an item is accepted and the result is formed
// (and any sub-dword merge written back) in the next, and no new item is
// taken until that one has executed. The result sits in an output register
// with one holding stage behind it, so the next item is taken while a result
// waits; items also stall while both are full. Address-port writes reduce
// the function index and register number to the store size; accesses of
// other ports return the unhandled flag.
// ----------------------------------------------------------------------------
module pci_config_space_port_unit #(
   parameter int NUM_FUNCTION_SLOTS = 256,
   parameter int DWORDS_PER_SPACE   = 64
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // byte_lane [1:0], access_size [3:2], write_data [35:4], zero [39:36]
   input  logic [pcics_pkg::REQ_DATA_W-1:0]   req_tdata,
   // kind [1:0], is_write [2]
   input  logic [pcics_pkg::REQ_USER_W-1:0]   req_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // read_data [31:0]
   output logic [pcics_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // unhandled [0]
   output logic [pcics_pkg::RSP_USER_W-1:0]   rsp_tuser
);
   import pcics_pkg::*;

   localparam int DEPTH  = NUM_FUNCTION_SLOTS * DWORDS_PER_SPACE;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int SLOT_W = $clog2(NUM_FUNCTION_SLOTS);
   localparam int DW_W   = $clog2(DWORDS_PER_SPACE);

   typedef enum logic [3:0] {
      S_CLEAR = 4'b0001,
      S_IDLE  = 4'b0010,
      S_EXEC  = 4'b0100,
      S_WAIT  = 4'b1000
   } state_type;

   state_type         state_ff, state_in;

   // captured item
   logic [1:0]        kind_ff;
   logic              wr_ff;
   logic [1:0]        lane_ff;
   logic [1:0]        size_ff;
   logic [31:0]       wdata_ff;

   // address port state
   logic [31:0]       latched_ff;
   logic [DW_W-1:0]   sel_reg_ff;
   logic [SLOT_W-1:0] sel_fn_ff;

   // result path
   logic              rsp_valid_ff;
   logic [31:0]       rsp_data_ff;
   logic              rsp_unh_ff;
   logic [31:0]       hold_data_ff;
   logic              hold_unh_ff;

   logic              req_accept;
   logic              out_free;
   logic              out_load;
   logic [31:0]       res_data;
   logic              res_unh;
   logic [ADDR_W-1:0] cell_addr;
   logic [31:0]       store_rd;
   logic [31:0]       merged;
   store_cmd_type     store_cmd;
   store_stat_type    store_stat;

   assign req_tready = (state_ff == S_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign out_load   = ((state_ff == S_EXEC) || (state_ff == S_WAIT)) && out_free;

   // store cell of the selected function and register
   assign cell_addr = ADDR_W'(ADDR_W'(sel_fn_ff) * ADDR_W'(DWORDS_PER_SPACE))
                    + ADDR_W'(sel_reg_ff);

   // control sequence
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_CLEAR: if (!store_stat.busy) state_in = S_IDLE;
         S_IDLE:  if (req_accept) state_in = S_EXEC;
         S_EXEC:  state_in = out_free ? S_IDLE : S_WAIT;
         S_WAIT:  if (out_free) state_in = S_IDLE;
         default: state_in = S_CLEAR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // item capture
   always_ff @(posedge clock) begin
      if (req_accept) begin
         kind_ff  <= req_tuser[1:0];
         wr_ff    <= req_tuser[2];
         lane_ff  <= req_tdata[1:0];
         size_ff  <= req_tdata[3:2];
         wdata_ff <= req_tdata[35:4];
      end
   end

   // result of the item in flight
   always_comb begin
      res_data = 32'h0;
      res_unh  = 1'b0;
      case (kind_ff)
         KIND_ADDR: if (!wr_ff) res_data = latched_ff;
         KIND_DATA: if (!wr_ff) res_data = lane_extract(store_rd, lane_ff, size_ff);
         default:   res_unh = 1'b1;
      endcase
   end

   assign merged = lane_merge(store_rd, wdata_ff, lane_ff, size_ff);

   // store access: read on accept, write back on execute
   assign store_cmd.rd = req_accept;
   assign store_cmd.wr = (state_ff == S_EXEC) && (kind_ff == KIND_DATA) && wr_ff;

   // address port latch
   always_ff @(posedge clock) begin
      if (reset) begin
         latched_ff <= '0;
         sel_reg_ff <= '0;
         sel_fn_ff  <= '0;
      end else if ((state_ff == S_EXEC) && (kind_ff == KIND_ADDR) && wr_ff) begin
         latched_ff <= wdata_ff;
         sel_reg_ff <= DW_W'(mod_narrow({2'b00, wdata_ff[7:2]}, DWORDS_PER_SPACE));
         sel_fn_ff  <= SLOT_W'(mod_narrow(wdata_ff[15:8], NUM_FUNCTION_SLOTS));
      end
   end

   // output register and holding stage
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_data_ff <= (state_ff == S_EXEC) ? res_data : hold_data_ff;
         rsp_unh_ff  <= (state_ff == S_EXEC) ? res_unh : hold_unh_ff;
      end
      if (state_ff == S_EXEC) begin
         hold_data_ff <= res_data;
         hold_unh_ff  <= res_unh;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_unh_ff;

   pcics_store #(
      .NUM_FUNCTION_SLOTS (NUM_FUNCTION_SLOTS),
      .DWORDS_PER_SPACE   (DWORDS_PER_SPACE)
   ) u_store (
      .clock   (clock),
      .reset   (reset),
      .cmd     (store_cmd),
      .addr    (cell_addr),
      .wr_data (merged),
      .rd_data (store_rd),
      .stat    (store_stat)
   );

   // no item taken while the store sweep runs
   assert property (@(posedge clock) disable iff (reset) store_stat.busy |-> !req_tready)
      else $error("item accepted during store sweep");

   // an accepted item is executed in the next cycle
   assert property (@(posedge clock) disable iff (reset) req_accept |=> (state_ff == S_EXEC))
      else $error("accepted item not executed");

   // store is written only while executing and never with a read
   assert property (@(posedge clock) disable iff (reset)
      store_cmd.wr |-> ((state_ff == S_EXEC) && !store_cmd.rd))
      else $error("store write outside execute");

   // a held result only exists while the output register is full
   assert property (@(posedge clock) disable iff (reset) (state_ff == S_WAIT) |-> rsp_valid_ff)
      else $error("holding stage used with empty output");

   // an unhandled access returns no data
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_unh_ff) |-> (rsp_data_ff == 32'h0))
      else $error("unhandled access returned data");

endmodule
